[rtl/aslm_pkg.sv]
// ----------------------------------------------------------------------------
// aslm_pkg - shared types and constants of the ADC sample level monitor
// Widths, reset values, register map, report characters and averaging
// constants.
// ----------------------------------------------------------------------------
`default_nettype none

package aslm_pkg;

  // Averaging window (ring depth)
  localparam int WINDOW   = 10;
  localparam int SLOT_W   = $clog2(WINDOW);

  // Field widths
  localparam int SAMPLE_W = 12;
  localparam int SUM_W    = 16;
  localparam int PERIOD_W = 16;
  localparam int LED_W    = 4;
  localparam int CHAR_W   = 8;
  localparam int AVG_W    = 12;
  localparam int REST_W   = 10;

  // Stream widths (whole bytes)
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 32;

  // Register port
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = CFG_ADDR_W - 2;

  localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_ONE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_TWO   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_THREE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_FOUR  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SWEEP_FLOOR = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SWEEP_CEIL  = 3'd5;

  // Reset values
  localparam logic [SAMPLE_W-1:0] LEVEL_ONE_RST   = 12'd820;
  localparam logic [SAMPLE_W-1:0] LEVEL_TWO_RST   = 12'd1640;
  localparam logic [SAMPLE_W-1:0] LEVEL_THREE_RST = 12'd2400;
  localparam logic [SAMPLE_W-1:0] LEVEL_FOUR_RST  = 12'd3200;
  localparam logic [PERIOD_W-1:0] SWEEP_FLOOR_RST = 16'd20;
  localparam logic [PERIOD_W-1:0] SWEEP_CEIL_RST  = 16'd250;
  localparam logic [PERIOD_W-1:0] PERIOD_RST      = 16'd249;

  // LED patterns
  localparam logic [LED_W-1:0] LED_ONE   = 4'b0001;
  localparam logic [LED_W-1:0] LED_TWO   = 4'b0010;
  localparam logic [LED_W-1:0] LED_THREE = 4'b0100;
  localparam logic [LED_W-1:0] LED_FOUR  = 4'b1000;
  localparam logic [LED_W-1:0] LED_ALL   = 4'b1111;

  // Report characters
  localparam logic [CHAR_W-1:0] CHAR_NONE = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_STAR = 8'h2A;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_CR   = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_LF   = 8'd10;

  // Position of a word within a report
  localparam logic [2:0] POS_STAR = 3'd0;
  localparam logic [2:0] POS_THOU = 3'd1;
  localparam logic [2:0] POS_HUND = 3'd2;
  localparam logic [2:0] POS_TENS = 3'd3;
  localparam logic [2:0] POS_UNIT = 3'd4;
  localparam logic [2:0] POS_CR   = 3'd5;

  // Divide by WINDOW: sum * DIV_RECIP >> DIV_SH, exact over all SUM_W-bit sums
  localparam int DIV_SH   = SUM_W + $clog2(WINDOW);
  localparam int RECIP_W  = SUM_W + 1;
  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] DIV_RECIP =
    RECIP_W'(((64'd1 << DIV_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [PERIOD_W-1:0] period_t;

  typedef struct packed {
    logic [3:0]        digit;
    logic [REST_W-1:0] rest;
  } digit_t;

endpackage

`default_nettype wire

[rtl/adc_sample_level_monitor_core.sv]
// ----------------------------------------------------------------------------
// adc_sample_level_monitor_core - converter sample level monitor
// Ring average with ASCII report, LED level pattern and period sweep.
// ----------------------------------------------------------------------------
// Each accepted 12-bit sample word is written into a ten-entry ring (cleared
// at reset) and yields one result word, except a report sample (the first
// sample, then every tenth): it yields six words '*', four decimal digits of
// the ring average and CR, with the LF owed going out as the single word of
// the next sample. The single output register sends one word per cycle
// while m_tready is high. Every word carries the LED pattern of its sample
// and the period value after that sample's sweep step. A new sample is
// taken in the same cycle that the last word of the previous one leaves.
// Registers sit on an APB port at byte addresses 0..20; pready is always
// high and writes are meant only while the block is idle.
`default_nettype none

module adc_sample_level_monitor_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Sample stream
  input  wire logic                              s_tvalid,
  output      logic                              s_tready,
  input  wire logic [aslm_pkg::S_TDATA_W-1:0]    s_tdata,   // [11:0] sample
  // Result stream
  output      logic                              m_tvalid,
  input  wire logic                              m_tready,
  // [3:0] led_pattern, [19:4] sweep_period, [27:20] char_byte
  output      logic [aslm_pkg::M_TDATA_W-1:0]    m_tdata,
  output      logic [0:0]                        m_tuser,   // [0] has_char
  output      logic                              m_tlast,
  // Register port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [aslm_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [aslm_pkg::CFG_DATA_W-1:0]   pwdata,
  output      logic [aslm_pkg::CFG_DATA_W-1:0]   prdata,
  output      logic                              pready
);

  import aslm_pkg::*;

  // ---------------------------------------------------------------- config
  sample_t level_one_limit;
  sample_t level_two_limit;
  sample_t level_three_limit;
  sample_t level_four_limit;
  period_t sweep_floor;
  period_t sweep_ceiling;

  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;

  assign pready    = 1'b1;
  assign cfg_index = paddr[CFG_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_one_limit   <= LEVEL_ONE_RST;
      level_two_limit   <= LEVEL_TWO_RST;
      level_three_limit <= LEVEL_THREE_RST;
      level_four_limit  <= LEVEL_FOUR_RST;
      sweep_floor       <= SWEEP_FLOOR_RST;
      sweep_ceiling     <= SWEEP_CEIL_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LEVEL_ONE:   level_one_limit   <= pwdata[SAMPLE_W-1:0];
        REG_LEVEL_TWO:   level_two_limit   <= pwdata[SAMPLE_W-1:0];
        REG_LEVEL_THREE: level_three_limit <= pwdata[SAMPLE_W-1:0];
        REG_LEVEL_FOUR:  level_four_limit  <= pwdata[SAMPLE_W-1:0];
        REG_SWEEP_FLOOR: sweep_floor       <= pwdata[PERIOD_W-1:0];
        REG_SWEEP_CEIL:  sweep_ceiling     <= pwdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_LEVEL_ONE:   prdata = CFG_DATA_W'(level_one_limit);
      REG_LEVEL_TWO:   prdata = CFG_DATA_W'(level_two_limit);
      REG_LEVEL_THREE: prdata = CFG_DATA_W'(level_three_limit);
      REG_LEVEL_FOUR:  prdata = CFG_DATA_W'(level_four_limit);
      REG_SWEEP_FLOOR: prdata = CFG_DATA_W'(sweep_floor);
      REG_SWEEP_CEIL:  prdata = CFG_DATA_W'(sweep_ceiling);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- state
  sample_t              sample_ring [WINDOW];
  logic [SUM_W-1:0]     ring_sum;
  logic [SLOT_W-1:0]    slot_index;
  period_t              period_value;
  logic                 sweep_falling;
  logic                 lf_pending;

  // Output register and report sequencing
  logic [LED_W-1:0]     out_led;
  period_t              out_period;
  logic                 out_report;
  logic                 out_lf;
  logic [2:0]           out_count;
  logic [SUM_W-1:0]     rep_sum;     // ring sum captured on a report sample
  logic [AVG_W-1:0]     avg;         // rep_sum / WINDOW, registered from rep_sum
  logic [REST_W-1:0]    rem;         // average left after the digits sent

  // ---------------------------------------------------------------- input side
  logic                 s_fire;
  logic                 out_take;
  sample_t              sample;
  logic [SLOT_W-1:0]    slot;
  logic [SLOT_W-1:0]    slot_next;
  logic                 report_now;
  logic [SUM_W-1:0]     ring_sum_next;
  period_t              period_next;
  logic                 flip;
  logic [LED_W-1:0]     led_next;
  logic [PROD_W-1:0]    avg_prod;

  assign out_take = m_tvalid && m_tready;
  // The output register frees up when its last word leaves
  assign s_tready = !m_tvalid || (m_tready && m_tlast);
  assign s_fire   = s_tvalid && s_tready;
  assign sample   = s_tdata[SAMPLE_W-1:0];

  always_comb begin
    if ({1'b0, slot_index} >= (SLOT_W+1)'(WINDOW)) slot = '0;
    else                                           slot = slot_index;
    report_now = (slot == '0);
    if (slot == SLOT_W'(WINDOW - 1)) slot_next = '0;
    else                             slot_next = slot + 1'b1;

    ring_sum_next = ring_sum - SUM_W'(sample_ring[slot]) + SUM_W'(sample);

    if (sample < level_one_limit)        led_next = LED_ONE;
    else if (sample < level_two_limit)   led_next = LED_TWO;
    else if (sample < level_three_limit) led_next = LED_THREE;
    else if (sample < level_four_limit)  led_next = LED_FOUR;
    else                                 led_next = LED_ALL;

    if (sweep_falling) period_next = period_value - 1'b1;
    else               period_next = period_value + 1'b1;
    flip = (period_next == sweep_floor) || (period_next == sweep_ceiling);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) sample_ring[i] <= '0;
      ring_sum      <= '0;
      slot_index    <= '0;
      period_value  <= PERIOD_RST;
      sweep_falling <= 1'b1;
      lf_pending    <= 1'b0;
    end else if (s_fire) begin
      sample_ring[slot] <= sample;
      ring_sum          <= ring_sum_next;
      slot_index        <= slot_next;
      period_value      <= period_next;
      sweep_falling     <= sweep_falling ^ flip;
      // A report leaves its LF to the next sample, which is never a report
      lf_pending        <= report_now;
    end
  end

  // ---------------------------------------------------------------- average
  assign avg_prod = PROD_W'(rep_sum) * PROD_W'(DIV_RECIP);

  always_ff @(posedge clk) begin
    if (s_fire && report_now) rep_sum <= ring_sum_next;
    avg <= AVG_W'(avg_prod >> DIV_SH);
  end

  // ---------------------------------------------------------------- digits
  logic [AVG_W-1:0] digit_src;
  logic [AVG_W-1:0] place;
  digit_t           split;

  function automatic digit_t split_digit(logic [AVG_W-1:0] v, logic [AVG_W-1:0] p);
    digit_t      r;
    logic [15:0] step;
    logic [15:0] rest;
    r.digit = '0;
    rest    = 16'(v);
    for (int k = 1; k < 10; k++) begin
      step = 16'(k) * 16'(p);
      if (16'(v) >= step) begin
        r.digit = 4'(k);
        rest    = 16'(v) - step;
      end
    end
    r.rest = rest[REST_W-1:0];
    return r;
  endfunction

  always_comb begin
    // avg is settled by the time the thousands word is shown
    if (out_count == POS_THOU) digit_src = avg;
    else                       digit_src = AVG_W'(rem);
    case (out_count)
      POS_THOU: place = 12'd1000;
      POS_HUND: place = 12'd100;
      POS_TENS: place = 12'd10;
      default:  place = 12'd1;
    endcase
    split = split_digit(digit_src, place);
  end

  // ---------------------------------------------------------------- output side
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid  <= 1'b0;
      out_count <= POS_STAR;
    end else if (s_fire) begin
      m_tvalid  <= 1'b1;
      out_count <= POS_STAR;
    end else if (out_take) begin
      if (m_tlast) m_tvalid <= 1'b0;
      else         out_count <= out_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      out_led    <= led_next;
      out_period <= period_next;
      out_report <= report_now;
      out_lf     <= lf_pending && !report_now;
    end
    if (out_take && out_report &&
        (out_count == POS_THOU || out_count == POS_HUND || out_count == POS_TENS))
      rem <= split.rest;
  end

  logic [CHAR_W-1:0] char_byte;
  logic              has_char;

  always_comb begin
    if (out_report) begin
      case (out_count)
        POS_STAR: char_byte = CHAR_STAR;
        POS_THOU,
        POS_HUND,
        POS_TENS,
        POS_UNIT: char_byte = CHAR_ZERO + CHAR_W'(split.digit);
        POS_CR:   char_byte = CHAR_CR;
        default:  char_byte = CHAR_NONE;
      endcase
    end else if (out_lf) begin
      char_byte = CHAR_LF;
    end else begin
      char_byte = CHAR_NONE;
    end
    has_char = out_report || out_lf;
  end

  assign m_tdata    = {4'b0000, char_byte, out_period, out_led};
  assign m_tuser[0] = has_char;
  assign m_tlast    = !out_report || (out_count == POS_CR);

  // ---------------------------------------------------------------- checks
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, slot_index} < (SLOT_W+1)'(WINDOW))
    else $error("slot index beyond ring depth");

  a_lf_not_at_report: assert property (@(posedge clk) disable iff (rst)
    lf_pending |-> (slot_index != '0))
    else $error("LF owed while next sample is a report");

  a_plain_single: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_report) |-> m_tlast)
    else $error("plain sample word not marked last");

  a_report_start: assert property (@(posedge clk) disable iff (rst)
    (s_fire && report_now) |=> (m_tvalid && out_report && out_count == POS_STAR))
    else $error("report did not start with star word");

  // the next sample may be taken in the CR cycle and settle the LF at once
  a_cr_then_lf: assert property (@(posedge clk) disable iff (rst)
    (out_take && out_report && m_tlast) |-> lf_pending)
    else $error("CR sent without LF owed");

endmodule

`default_nettype wire

[sim/aslm_report_checker.sv]
// ----------------------------------------------------------------------------
// aslm_report_checker - result checker for the ADC sample level monitor
// Follows register writes and accepted sample words, predicts every result
// word (LED level, sweep period, report characters, tlast) and compares each
// accepted result word with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module aslm_report_checker
  import aslm_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_tvalid,
  input  wire logic                    s_tready,
  input  wire logic [S_TDATA_W-1:0]    s_tdata,   // [11:0] sample
  input  wire logic                    m_tvalid,
  input  wire logic                    m_tready,
  // [3:0] led_pattern, [19:4] sweep_period, [27:20] char_byte
  input  wire logic [M_TDATA_W-1:0]    m_tdata,
  input  wire logic [0:0]              m_tuser,   // [0] has_char
  input  wire logic                    m_tlast,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [CFG_ADDR_W-1:0]   paddr,
  input  wire logic [CFG_DATA_W-1:0]   pwdata,
  input  wire logic                    pready,
  output int                           mismatches,
  output int                           pending_words
);

  localparam int PERIOD_LSB = LED_W;
  localparam int CHAR_LSB   = LED_W + PERIOD_W;
  localparam int PAD_LSB    = CHAR_LSB + CHAR_W;

  typedef struct packed {
    logic [LED_W-1:0]  led;
    period_t           period;
    logic              has_char;
    logic [CHAR_W-1:0] chr;
    logic              last;
  } result_word_t;

  result_word_t expected_words[$];

  // Shadow of the block's registers and state
  sample_t          level_limit [4];
  period_t          sweep_floor;
  period_t          sweep_ceil;
  sample_t          ring [WINDOW];
  logic [SUM_W-1:0] ring_sum;
  int               next_slot;
  period_t          sweep_now;
  logic             sweep_down;
  logic             lf_owed;

  function automatic void clear_state();
    level_limit[0] = LEVEL_ONE_RST;
    level_limit[1] = LEVEL_TWO_RST;
    level_limit[2] = LEVEL_THREE_RST;
    level_limit[3] = LEVEL_FOUR_RST;
    sweep_floor = SWEEP_FLOOR_RST;
    sweep_ceil  = SWEEP_CEIL_RST;
    foreach (ring[i]) ring[i] = '0;
    ring_sum   = '0;
    next_slot  = 0;
    sweep_now  = PERIOD_RST;
    sweep_down = 1'b1;
    lf_owed    = 1'b0;
    expected_words.delete();
  endfunction

  function automatic logic [LED_W-1:0] led_for(input sample_t s);
    // first limit the sample is below wins, even if limits are out of order
    if (s < level_limit[0]) return LED_ONE;
    if (s < level_limit[1]) return LED_TWO;
    if (s < level_limit[2]) return LED_THREE;
    if (s < level_limit[3]) return LED_FOUR;
    return LED_ALL;
  endfunction

  function automatic void push_word(input logic [LED_W-1:0] led, input logic has,
                                    input logic [CHAR_W-1:0] chr, input logic last);
    result_word_t w;
    w.led      = led;
    w.period   = sweep_now;
    w.has_char = has;
    w.chr      = chr;
    w.last     = last;
    expected_words.push_back(w);
  endfunction

  function automatic void predict_words(input sample_t s);
    int unsigned      scale [4] = '{1000, 100, 10, 1};
    int               slot;
    int               made;
    logic [LED_W-1:0] led;
    logic [SUM_W-1:0] avg;
    result_word_t     w;

    slot = (next_slot >= WINDOW) ? 0 : next_slot;
    ring_sum   = ring_sum - ring[slot] + s;
    ring[slot] = s;
    next_slot  = (slot + 1 >= WINDOW) ? 0 : slot + 1;
    led = led_for(s);

    // one sweep step per sample, direction flips on an exact bound match
    sweep_now = sweep_down ? sweep_now - 1'b1 : sweep_now + 1'b1;
    if (sweep_now == sweep_floor || sweep_now == sweep_ceil) sweep_down = !sweep_down;

    if (slot == 0) begin
      avg  = ring_sum / WINDOW;
      made = 0;
      if (lf_owed) begin
        push_word(led, 1'b1, CHAR_LF, 1'b0);
        made++;
        lf_owed = 1'b0;
      end
      push_word(led, 1'b1, CHAR_STAR, 1'b0);
      for (int i = 0; i < 4; i++)
        push_word(led, 1'b1, CHAR_ZERO + CHAR_W'((avg / scale[i]) % 10), 1'b0);
      made += 5;
      // CR closes this sample's words, LF is owed to the next sample
      if (made < 6) begin
        push_word(led, 1'b1, CHAR_CR, 1'b1);
        lf_owed = 1'b1;
      end else begin
        w = expected_words.pop_back();
        w.last = 1'b1;
        expected_words.push_back(w);
      end
    end else if (lf_owed) begin
      push_word(led, 1'b1, CHAR_LF, 1'b1);
      lf_owed = 1'b0;
    end else begin
      push_word(led, 1'b0, CHAR_NONE, 1'b1);
    end
  endfunction

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_word();
    result_word_t want;
    if (expected_words.size() == 0) begin
      $display("%0t: result word with none expected, expected nothing, actual tdata %h",
               $time, m_tdata);
      mismatches++;
    end else begin
      want = expected_words.pop_front();
      compare_field("led_pattern", want.led, m_tdata[PERIOD_LSB-1:0]);
      compare_field("sweep_period", want.period, m_tdata[CHAR_LSB-1:PERIOD_LSB]);
      compare_field("char_byte", want.chr, m_tdata[PAD_LSB-1:CHAR_LSB]);
      compare_field("tdata padding", 0, m_tdata[M_TDATA_W-1:PAD_LSB]);
      compare_field("has_char", want.has_char, m_tuser[0]);
      compare_field("last", want.last, m_tlast);
    end
  endfunction

  initial begin
    mismatches    = 0;
    pending_words = 0;
    clear_state();
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[CFG_ADDR_W-1:2])
          REG_LEVEL_ONE:   level_limit[0] = pwdata[SAMPLE_W-1:0];
          REG_LEVEL_TWO:   level_limit[1] = pwdata[SAMPLE_W-1:0];
          REG_LEVEL_THREE: level_limit[2] = pwdata[SAMPLE_W-1:0];
          REG_LEVEL_FOUR:  level_limit[3] = pwdata[SAMPLE_W-1:0];
          REG_SWEEP_FLOOR: sweep_floor    = pwdata[PERIOD_W-1:0];
          REG_SWEEP_CEIL:  sweep_ceil     = pwdata[PERIOD_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_words(s_tdata[SAMPLE_W-1:0]);
      if (m_tvalid && m_tready) check_word();
    end
    pending_words = expected_words.size();
  end

endmodule

`default_nettype wire

[sim/adc_sample_level_monitor_core_test.sv]
// ----------------------------------------------------------------------------
// adc_sample_level_monitor_core_test - stimulus and verdict for the monitor
// Feeds sample words through directed cases and several register settings
// with random idling on both streams; the report checker beside the block
// predicts and compares every result word.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_sample_level_monitor_core_test;
  import aslm_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;  // far above the slowest legal run
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_WAIT     = 10;

  logic                  clk     = 1'b0;
  logic                  rst     = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic [S_TDATA_W-1:0]  s_tdata  = '0;
  logic                  m_tready = 1'b0;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr    = '0;
  logic [CFG_DATA_W-1:0] pwdata   = '0;

  logic                  s_tready;
  logic                  m_tvalid;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic [0:0]            m_tuser;
  logic                  m_tlast;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int mismatches;
  int pending_words;
  int cycle_count = 0;

  // Stimulus bookkeeping: limits as written (to aim samples at the edges)
  // and the number of samples sent (the sweep position while no bound is met)
  sample_t level_limit [4] = '{LEVEL_ONE_RST, LEVEL_TWO_RST, LEVEL_THREE_RST,
                               LEVEL_FOUR_RST};
  int      samples_sent = 0;
  logic    no_idle      = 1'b0;  // phase runs both streams flat out

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  adc_sample_level_monitor_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  aslm_report_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .mismatches    (mismatches),
    .pending_words (pending_words)
  );

  // Hard stop if words stop flowing or a prediction is never met
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int draw_wait();
    if (no_idle) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // Result side: random stall before each word, ready held until it moves.
  // ready is only lowered when a stall is drawn, so it never toggles twice
  // in one step.
  initial begin
    int stall;
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Sample side: optional gap, then valid held until the word is taken.
  // valid stays high across back-to-back words.
  task automatic send_sample(input sample_t value);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= S_TDATA_W'(value);
    do @(posedge clk); while (!s_tready);
    samples_sent++;
  endtask

  // One APB write; psel stays up so writes run back to back.
  // Junk above the register width checks that unused bits are ignored.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input int unsigned value,
                           input int width);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= ($urandom() << width) | value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic program_regs(input int unsigned lim1, input int unsigned lim2,
                              input int unsigned lim3, input int unsigned lim4,
                              input int unsigned floor_val, input int unsigned ceil_val);
    level_limit[0] = sample_t'(lim1);
    level_limit[1] = sample_t'(lim2);
    level_limit[2] = sample_t'(lim3);
    level_limit[3] = sample_t'(lim4);
    write_reg(REG_LEVEL_ONE,   lim1, SAMPLE_W);
    write_reg(REG_LEVEL_TWO,   lim2, SAMPLE_W);
    write_reg(REG_LEVEL_THREE, lim3, SAMPLE_W);
    write_reg(REG_LEVEL_FOUR,  lim4, SAMPLE_W);
    write_reg(REG_SWEEP_FLOOR, floor_val, PERIOD_W);
    write_reg(REG_SWEEP_CEIL,  ceil_val,  PERIOD_W);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Stop sending and wait until every predicted word has come out
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random samples, biased toward both ends and the limit edges
  function automatic sample_t pick_sample();
    int lim;
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3: begin
        lim = level_limit[$urandom_range(0, 3)];
        return sample_t'(lim + $urandom_range(0, 2) - 1);
      end
      default: return sample_t'($urandom());
    endcase
  endfunction

  task automatic run_phase(input int count);
    for (int i = 0; i < count; i++) send_sample(pick_sample());
  endtask

  // Sweep position; exact as long as no bound has been met since reset
  function automatic period_t sweep_position();
    return period_t'(PERIOD_RST - samples_sent);
  endfunction

  function automatic int unsigned far_bound();
    return $urandom_range(1000, 60000);
  endfunction

  initial begin
    int unsigned lim_a;
    int unsigned lim_b;
    int unsigned lim_c;
    period_t     pos;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset settings. First sample is a report (average 0),
    // then every limit edge, then a run of full-scale samples so the third
    // report shows the top average. Each report's LF rides on the next word.
    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'd819);
    send_sample(12'd820);
    send_sample(12'd1639);
    send_sample(12'd1640);
    send_sample(12'd2399);
    send_sample(12'd2400);
    send_sample(12'd3199);
    send_sample(12'd3200);
    for (int i = 0; i < 11; i++) send_sample(12'd4095);
    send_sample(12'h555);
    send_sample(12'hAAA);
    settle();

    // Random phases. Bounds stay out of the sweep's way until the wrap,
    // so the period only falls: 249 down through zero and past 65535.

    // all limits zero: every sample lights all four; sweep regs at extremes
    program_regs(0, 0, 0, 0, 0, 16'hFFFF);
    run_phase(36);
    settle();

    // all limits full scale, floor above ceiling; no idling at all
    no_idle = 1'b1;
    program_regs(4095, 4095, 4095, 4095, 16'hFFFF, 0);
    run_phase(36);
    settle();
    no_idle = 1'b0;

    // ordered random limits
    lim_a = $urandom_range(0, 1300);
    lim_b = lim_a + $urandom_range(0, 1300);
    lim_c = lim_b + $urandom_range(0, 1300);
    program_regs(lim_a, lim_b, lim_c, lim_c + $urandom_range(0, 200),
                 far_bound(), far_bound());
    run_phase(36);
    settle();

    // limits out of order
    no_idle = 1'($urandom_range(0, 1));
    program_regs($urandom_range(0, 4095), $urandom_range(0, 4095),
                 $urandom_range(0, 4095), $urandom_range(0, 4095),
                 far_bound(), far_bound());
    run_phase(36);
    settle();
    no_idle = 1'b0;

    // reset limits again; run the sweep through zero until six below wrap
    program_regs(LEVEL_ONE_RST, LEVEL_TWO_RST, LEVEL_THREE_RST, LEVEL_FOUR_RST,
                 far_bound(), far_bound());
    run_phase(int'(sweep_position()) + 6);
    settle();

    // tight bounds around the current period: the sweep bounces
    pos = sweep_position();
    program_regs($urandom_range(0, 4095), $urandom_range(0, 4095),
                 $urandom_range(0, 4095), $urandom_range(0, 4095),
                 period_t'(pos - 4), period_t'(pos + 3));
    run_phase(24);
    settle();

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
